// ===== rtl/pcg32_random_generator_assert.svh =====
// assertion macros shared by the pcg32 generator rtl
`ifndef PCG32_RANDOM_GENERATOR_ASSERT_SVH
`define PCG32_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcg32_pkg.sv =====
// types, constants and helper functions for the pcg32 generator
`timescale 1ns / 1ps

package pcg32_pkg;

  // lcg constants
  localparam logic [63:0] LcgMult       = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LcgResetState = 64'h853C_49E6_748F_EA9B;
  localparam logic [63:0] LcgResetInc   = 64'hDA3E_39CB_94B9_5BDB;

  // divider width
  localparam int unsigned DivBits = 32;
  localparam int unsigned DivCntW = $clog2(DivBits);

  // request op codes
  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_BOUNDED = 2'd1;
  localparam logic [1:0] OP_RESEED  = 2'd2;

  // configuration register indexes
  localparam logic REG_SEED_STATE  = 1'b0;
  localparam logic REG_SEED_STREAM = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THRESH,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CHECK,
    ST_REDUCE,
    ST_FINISH
  } fsm_e;

  // what the current request does after each advance
  typedef enum logic [1:0] {
    MODE_RAW,
    MODE_BOUNDED,
    MODE_SEED_FIRST,
    MODE_SEED_SECOND
  } mode_e;

  // divider start request
  typedef struct packed {
    logic                 start;
    logic [DivBits-1:0]   dividend;
    logic [DivBits-1:0]   divisor;
  } div_req_t;

  // divider status
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DivBits-1:0]   remainder;
  } div_rsp_t;

  // xsh-rr output permutation of a 64-bit state
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] mixed;
    logic [31:0] x;
    logic [4:0]  rot;
    logic [63:0] dbl;
    mixed = ((s >> 18) ^ s) >> 27;
    x     = mixed[31:0];
    rot   = s[63:59];
    dbl   = {x, x} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ===== rtl/pcg32_divider.sv =====
// iterative restoring divider, one quotient bit per cycle, remainder out
`timescale 1ns / 1ps

module pcg32_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcg32_pkg::div_req_t req_i,
  output pcg32_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = pcg32_pkg::DivBits;
  localparam int unsigned CW = pcg32_pkg::DivCntW;
  localparam logic [CW-1:0] LastCnt = CW'(W - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvd_q, dvd_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // one restoring step
  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  // next-state logic
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/pcg32_random_generator.sv =====
// pcg32 xsh-rr generator: raw draws, unbiased bounded draws and reseeding
// one request in flight at a time; a rejected bounded draw triggers another advance
// the 32-step remainder divider (run twice per bounded draw with a nonzero bound)
//   and the advance over states MUL0 to MUL3 through one shared 32x32 multiplier set the pace
// reset: state 0x853c49e6748fea9b, increment 0xda3e39cb94b95bdb, seeds zero
`timescale 1ns / 1ps
`include "pcg32_random_generator_assert.svh"

module pcg32_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o
);

  localparam logic [31:0] MultLo = pcg32_pkg::LcgMult[31:0];
  localparam logic [31:0] MultHi = pcg32_pkg::LcgMult[63:32];

  pcg32_pkg::fsm_e  fsm_q, fsm_d;
  pcg32_pkg::mode_e mode_q, mode_d;

  logic [63:0] state_q, state_d;
  logic [63:0] inc_q, inc_d;
  logic [63:0] seed_state_q;
  logic [62:0] seed_stream_q;
  logic        out_valid_q, out_valid_d;
  logic        out_load;

  logic [31:0] bound_q, bound_d;
  logic [31:0] thresh_q, thresh_d;
  logic [31:0] draw_q, draw_d;
  logic [31:0] res_q, res_d;
  logic [31:0] value_q;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  pcg32_pkg::div_req_t div_req;
  pcg32_pkg::div_rsp_t div_rsp;

  // shared remainder unit
  pcg32_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared 32x32 multiplier, operands picked by the advance step
  always_comb begin
    mul_a = state_q[31:0];
    mul_b = MultLo;
    case (fsm_q)
      pcg32_pkg::ST_MUL1: mul_b = MultHi;
      pcg32_pkg::ST_MUL2: mul_a = state_q[63:32];
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign in_ready_o = (fsm_q == pcg32_pkg::ST_IDLE);

  // sequencer
  always_comb begin
    fsm_d    = fsm_q;
    mode_d   = mode_q;
    state_d  = state_q;
    inc_d    = inc_q;
    bound_d  = bound_q;
    thresh_d = thresh_q;
    draw_d   = draw_q;
    res_d    = res_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    out_load = 1'b0;
    div_req  = '0;
    unique case (fsm_q)
      pcg32_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          bound_d = bound_i;
          case (op_i)
            pcg32_pkg::OP_RAW: begin
              mode_d = pcg32_pkg::MODE_RAW;
              fsm_d  = pcg32_pkg::ST_MUL0;
            end
            pcg32_pkg::OP_BOUNDED: begin
              if (bound_i == '0) begin
                // zero bound means full range
                mode_d = pcg32_pkg::MODE_RAW;
                fsm_d  = pcg32_pkg::ST_MUL0;
              end else begin
                mode_d           = pcg32_pkg::MODE_BOUNDED;
                div_req.start    = 1'b1;
                div_req.dividend = 32'd0 - bound_i;
                div_req.divisor  = bound_i;
                fsm_d            = pcg32_pkg::ST_THRESH;
              end
            end
            pcg32_pkg::OP_RESEED: begin
              mode_d  = pcg32_pkg::MODE_SEED_FIRST;
              state_d = '0;
              inc_d   = {seed_stream_q, 1'b1};
              fsm_d   = pcg32_pkg::ST_MUL0;
            end
            default: ;
          endcase
        end
      end
      pcg32_pkg::ST_THRESH: begin
        if (div_rsp.done) begin
          thresh_d = div_rsp.remainder;
          fsm_d    = pcg32_pkg::ST_MUL0;
        end
      end
      // advance: state * mult + inc over three partial products
      pcg32_pkg::ST_MUL0: begin
        draw_d = pcg32_pkg::xsh_rr(state_q);
        prod_d = mul_p;
        fsm_d  = pcg32_pkg::ST_MUL1;
      end
      pcg32_pkg::ST_MUL1: begin
        acc_d  = prod_q + inc_q;
        prod_d = mul_p;
        fsm_d  = pcg32_pkg::ST_MUL2;
      end
      pcg32_pkg::ST_MUL2: begin
        acc_d  = acc_q + {prod_q[31:0], 32'd0};
        prod_d = mul_p;
        fsm_d  = pcg32_pkg::ST_MUL3;
      end
      pcg32_pkg::ST_MUL3: begin
        state_d = acc_q + {prod_q[31:0], 32'd0};
        fsm_d   = pcg32_pkg::ST_CHECK;
      end
      pcg32_pkg::ST_CHECK: begin
        unique case (mode_q)
          pcg32_pkg::MODE_RAW: begin
            res_d = draw_q;
            fsm_d = pcg32_pkg::ST_FINISH;
          end
          pcg32_pkg::MODE_BOUNDED: begin
            if (draw_q < thresh_q) begin
              // rejected draw, take another
              fsm_d = pcg32_pkg::ST_MUL0;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = draw_q;
              div_req.divisor  = bound_q;
              fsm_d            = pcg32_pkg::ST_REDUCE;
            end
          end
          pcg32_pkg::MODE_SEED_FIRST: begin
            state_d = state_q + seed_state_q;
            mode_d  = pcg32_pkg::MODE_SEED_SECOND;
            fsm_d   = pcg32_pkg::ST_MUL0;
          end
          pcg32_pkg::MODE_SEED_SECOND: begin
            fsm_d = pcg32_pkg::ST_IDLE;
          end
        endcase
      end
      pcg32_pkg::ST_REDUCE: begin
        if (div_rsp.done) begin
          res_d = div_rsp.remainder;
          fsm_d = pcg32_pkg::ST_FINISH;
        end
      end
      pcg32_pkg::ST_FINISH: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          fsm_d    = pcg32_pkg::ST_IDLE;
        end
      end
      default: fsm_d = pcg32_pkg::ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q         <= pcg32_pkg::ST_IDLE;
      mode_q        <= pcg32_pkg::MODE_RAW;
      state_q       <= pcg32_pkg::LcgResetState;
      inc_q         <= pcg32_pkg::LcgResetInc;
      seed_state_q  <= '0;
      seed_stream_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      mode_q      <= mode_d;
      state_q     <= state_d;
      inc_q       <= inc_d;
      out_valid_q <= out_valid_d;
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pcg32_pkg::REG_SEED_STATE:  seed_state_q  <= cfg_data_i;
          pcg32_pkg::REG_SEED_STREAM: seed_stream_q <= cfg_data_i[62:0];
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    bound_q  <= bound_d;
    thresh_q <= thresh_d;
    draw_q   <= draw_d;
    res_q    <= res_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    if (out_load) begin
      value_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // checks
  `PCG_ASSERT_NOW(a_inc_odd, 1'b1, inc_q[0], "stream increment lost its low bit")
  `PCG_ASSERT_NOW(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `PCG_ASSERT_NEXT(a_bounded_range, out_load && (mode_q == pcg32_pkg::MODE_BOUNDED), value_o < bound_q, "bounded result not below bound")

endmodule

// ===== sim/pcg32_random_generator_tb.sv =====
// self-checking testbench for the pcg32 xsh-rr generator with its own prediction
`timescale 1ns / 1ps

module pcg32_random_generator_tb;

  // generator constants kept apart from the rtl
  localparam logic [63:0] GEN_MULT       = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] GEN_INIT_STATE = 64'h853C_49E6_748F_EA9B;
  localparam logic [63:0] GEN_INIT_INC   = 64'hDA3E_39CB_94B9_5BDB;

  // op code the block drops without a result
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SEG_REQS     = 266;
  localparam int unsigned NUM_SEGS     = 6;
  localparam int unsigned SETTLE_CYC   = 20;
  localparam int unsigned TAIL_CYC     = 30;
  localparam int unsigned HOLD_CYC     = 300;
  localparam int unsigned NUM_DIRECTED = 21;

  // one row of the directed table
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] bound;
    logic        fixed;
    logic [31:0] want;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i        = pcg32_pkg::OP_RAW;
  logic [31:0] bound_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] value_o;

  // predictor state
  logic [63:0] gen_state     = GEN_INIT_STATE;
  logic [63:0] gen_inc       = GEN_INIT_INC;
  logic [63:0] seed_state_r  = '0;
  logic [62:0] seed_stream_r = '0;
  logic [31:0] value_fifo [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;
  int unsigned raw_cnt       = 0;
  int unsigned bnd_cnt       = 0;
  int unsigned reseed_cnt    = 0;
  int unsigned drop_cnt      = 0;
  int unsigned result_cnt    = 0;
  logic [31:0] want_val;

  // directed requests: reset state, bound extremes, unused op, reseeds
  dir_row_t directed_tbl [NUM_DIRECTED] = '{
    '{pcg32_pkg::OP_RAW,     32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_RAW,     32'hFFFF_FFFF, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h0000_0001, 1'b1, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h0000_0002, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h0000_0003, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h8000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h8000_0001, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_UNUSED,             32'hFFFF_FFFF, 1'b0, 32'h0},
    '{pcg32_pkg::OP_RAW,     32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_RESEED,  32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_RAW,     32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h0000_0006, 1'b0, 32'h0},
    '{pcg32_pkg::OP_RESEED,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{pcg32_pkg::OP_RESEED,  32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'h0000_0001, 1'b1, 32'h0},
    '{OP_UNUSED,             32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_RAW,     32'h0000_0000, 1'b0, 32'h0},
    '{pcg32_pkg::OP_BOUNDED, 32'hAAAA_5555, 1'b0, 32'h0}
  };

  pcg32_random_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .bound_i    (bound_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("pcg32_random_generator_tb: done, errors");
      $finish;
    end
  end

  // one lcg advance, returns the permuted word of the old state
  function automatic logic [31:0] draw_word();
    logic [63:0] old;
    logic [31:0] xs;
    int unsigned rot;
    old       = gen_state;
    gen_state = old * GEN_MULT + gen_inc;
    xs        = 32'(((old >> 18) ^ old) >> 27);
    rot       = 32'(old[63:59]);
    return (xs >> rot) | (xs << ((32 - rot) & 31));
  endfunction

  // unbiased draw below bnd by rejection; zero means full range
  function automatic logic [31:0] draw_below(logic [31:0] bnd);
    logic [31:0] thr;
    logic [31:0] r;
    if (bnd == 32'd0) return draw_word();
    thr = (32'd0 - bnd) % bnd;
    do r = draw_word(); while (r < thr);
    return r % bnd;
  endfunction

  // expected value for an accepted request, queued when there is one
  function automatic void predict_request(logic [1:0] op, logic [31:0] bnd,
                                          logic fixed, logic [31:0] want);
    logic [31:0] v;
    case (op)
      pcg32_pkg::OP_RAW: begin
        v = draw_word();
        value_fifo.push_back(fixed ? want : v);
        raw_cnt++;
      end
      pcg32_pkg::OP_BOUNDED: begin
        v = draw_below(bnd);
        value_fifo.push_back(fixed ? want : v);
        bnd_cnt++;
      end
      pcg32_pkg::OP_RESEED: begin
        gen_state = '0;
        gen_inc   = {seed_stream_r, 1'b1};
        void'(draw_word());
        gen_state = gen_state + seed_state_r;
        void'(draw_word());
        reseed_cnt++;
      end
      default: drop_cnt++;
    endcase
  endfunction

  // offer one request, with random sender gaps, and wait for acceptance
  task automatic send_req(input logic [1:0] op, input logic [31:0] bnd,
                          input logic fixed, input logic [31:0] want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    bound_i    <= bnd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(op, bnd, fixed, want);
  endtask

  // let every expected value arrive and the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (value_fifo.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // write both seed registers back to back
  task automatic load_seeds(input logic [63:0] st, input logic [63:0] sm);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pcg32_pkg::REG_SEED_STATE;
    cfg_data_i <= st;
    @(posedge clk_i);
    seed_state_r = st;
    cfg_idx_i  <= pcg32_pkg::REG_SEED_STREAM;
    cfg_data_i <= sm;
    @(posedge clk_i);
    seed_stream_r = sm[62:0];
    cfg_we_i <= 1'b0;
  endtask

  // bound mix: small most often, some zero, near half range and near full range
  function automatic logic [31:0] pick_bound();
    case ($urandom_range(9)) inside
      0:       return 32'd0;
      [1:4]:   return 32'($urandom_range(1, 100));
      5:       return 32'($urandom_range(101, 65535));
      6:       return 32'h8000_0000 + 32'($urandom_range(0, 255));
      7:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result check against the oldest expected value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_cnt++;
      if (value_fifo.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected, actual %h", $time, value_o);
      end else begin
        want_val = value_fifo.pop_front();
        if (value_o !== want_val) begin
          err_cnt++;
          $display("%0t: value mismatch, expected %h actual %h", $time, want_val, value_o);
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [1:0]  op;
    logic [31:0] bnd;
    logic [63:0] st;
    logic [63:0] sm;
    int unsigned counted;
    int unsigned pick;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, seeds still at reset value
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_req(directed_tbl[i].op, directed_tbl[i].bound,
               directed_tbl[i].fixed, directed_tbl[i].want);
    end

    // random segments, each with its own seeds and one of three idling mixes
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      settle();
      case (seg)
        0: begin st = 64'd42;         sm = 64'd54;         end
        1: begin st = '1;             sm = '1;             end
        2: begin st = '0;             sm = '0;             end
        4: begin st = 64'h8000_0000_0000_0000; sm = 64'h7FFF_FFFF_FFFF_FFFF; end
        default: begin
          st = {$urandom(), $urandom()};
          sm = {$urandom(), $urandom()};
        end
      endcase
      load_seeds(st, sm);
      if (seg < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 59;
      end else if (seg < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // reseed early so most draws run from the new seeds
      send_req(pcg32_pkg::OP_RESEED, $urandom(), 1'b0, 32'h0);
      counted = 1;
      while (counted < SEG_REQS) begin
        if (seg == 4 && counted == 40) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 35) op = pcg32_pkg::OP_RAW;
        else if (pick < 82) op = pcg32_pkg::OP_BOUNDED;
        else if (pick < 92) op = pcg32_pkg::OP_RESEED;
        else op = OP_UNUSED;
        bnd = ($urandom_range(3) == 0) ? $urandom() : pick_bound();
        send_req(op, bnd, 1'b0, 32'h0);
        if (op != OP_UNUSED) counted++;
      end
    end

    // drain and look for stray results
    in_valid_i <= 1'b0;
    while (value_fifo.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("run: %0d raw, %0d bounded, %0d reseed, %0d dropped requests, %0d results",
             raw_cnt, bnd_cnt, reseed_cnt, drop_cnt, result_cnt);
    $display("run: %0d seed settings, three idling mixes, one long output hold-off",
             NUM_SEGS + 1);
    if (err_cnt == 0 && value_fifo.size() == 0) begin
      $display("pcg32_random_generator_tb: done, clean");
    end else begin
      $display("pcg32_random_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
